// ===== rtl/core/dmba_pkg.sv =====
`default_nettype none

package dmba_pkg;

    localparam int MAX_DEVICES_DEF = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int BYTE_BITS_DEF   = 40;

    // fixed field widths
    localparam int FIELD_BYTES_W = 40;
    localparam int TAG_W         = 8;
    localparam int DEV_W         = 3;
    localparam int CFG_IDX_W     = 3;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP3   = 3'd4;

    typedef enum logic [2:0] {
        STAT_GRANT   = 3'd0,
        STAT_QUEUED  = 3'd1,
        STAT_INVALID = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_DONE    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN
    } t_state;

    // update strobes for the per-device budget and queue pointers
    typedef struct packed {
        logic sub;
        logic add;
        logic push;
        logic pop;
    } t_bud_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/dmba_wait_mem.sv =====
`default_nettype none

module dmba_wait_mem import dmba_pkg::*; #(
    parameter int DEPTH  = MAX_DEVICES_DEF * QUEUE_DEPTH_DEF,
    parameter int WIDTH  = BYTE_BITS_DEF + TAG_W,
    parameter int ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/dmba_budget.sv =====
`default_nettype none

module dmba_budget import dmba_pkg::*; #(
    parameter int MAX_DEVICES = MAX_DEVICES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int BYTE_BITS   = BYTE_BITS_DEF,
    parameter int DEV_IW      = 2,
    parameter int PTR_W       = 4,
    parameter int CNT_W       = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_ld_en,
    input  wire logic [DEV_IW-1:0]    i_ld_dev,
    input  wire logic [BYTE_BITS-1:0] i_ld_val,
    input  wire logic [DEV_IW-1:0]    i_dev,
    input  wire t_bud_cmd             i_cmd,
    input  wire logic [BYTE_BITS-1:0] i_opnd,
    output logic      [BYTE_BITS-1:0] o_free,
    output logic      [PTR_W-1:0]     o_head,
    output logic      [PTR_W-1:0]     o_head_next,
    output logic      [PTR_W-1:0]     o_tail,
    output logic      [CNT_W-1:0]     o_cnt
);

    logic [BYTE_BITS-1:0] r_free [MAX_DEVICES];
    logic [PTR_W-1:0]     r_head [MAX_DEVICES];
    logic [PTR_W-1:0]     r_tail [MAX_DEVICES];
    logic [CNT_W-1:0]     r_cnt  [MAX_DEVICES];

    logic [BYTE_BITS:0]   sum;
    logic [BYTE_BITS-1:0] n_free;
    logic [PTR_W-1:0]     tail_next;

    assign o_free = r_free[i_dev];
    assign o_head = r_head[i_dev];
    assign o_tail = r_tail[i_dev];
    assign o_cnt  = r_cnt[i_dev];

    assign o_head_next = (o_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : o_head + 1'b1;
    assign tail_next   = (o_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : o_tail + 1'b1;

    // saturating add on release, plain subtract on grant
    assign sum = {1'b0, o_free} + {1'b0, i_opnd};

    always_comb begin
        n_free = o_free;
        if (i_cmd.add) begin
            n_free = sum[BYTE_BITS] ? '1 : sum[BYTE_BITS-1:0];
        end else if (i_cmd.sub) begin
            n_free = o_free - i_opnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DEVICES; i++) begin
                r_free[i] <= '0;
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < MAX_DEVICES; i++) begin
                if (i_ld_en && (i_ld_dev == DEV_IW'(i))) begin
                    r_free[i] <= i_ld_val;
                end else if ((i_cmd.add || i_cmd.sub) && (i_dev == DEV_IW'(i))) begin
                    r_free[i] <= n_free;
                end
                if (i_dev == DEV_IW'(i)) begin
                    if (i_cmd.push) begin
                        r_tail[i] <= tail_next;
                        r_cnt[i]  <= o_cnt + 1'b1;
                    end else if (i_cmd.pop) begin
                        r_head[i] <= o_head_next;
                        r_cnt[i]  <= o_cnt - 1'b1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/device_memory_budget_allocator_unit.sv =====
`default_nettype none

// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------------
// request  | i_in_valid / o_in_ready    | i_op i_device i_byte_count i_requester
// result   | o_out_valid / i_out_ready  | o_status o_grant_requester o_grant_device
//          |                            |   o_grant_bytes o_last
// config   | i_cfg_we (no wait)         | i_cfg_idx i_cfg_wdata
//
// An allocation is accepted, then does one read-compare-write of the device
// budget; a request to an invalid device only returns its status. A release
// does a budget add, then one wait-queue memory read per drained grant, the
// read for the next head issued while the current head is granted.
// Synchronous active-low reset zeroes all budgets and queue pointers; the
// wait-queue memory is not cleared. A stalled result register stalls the
// sequencer but the next request is still taken while a result waits.

module device_memory_budget_allocator_unit import dmba_pkg::*; #(
    parameter int MAX_DEVICES = MAX_DEVICES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int BYTE_BITS   = BYTE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [FIELD_BYTES_W-1:0] i_cfg_wdata,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_op,
    input  wire logic [DEV_W-1:0]         i_device,
    input  wire logic [FIELD_BYTES_W-1:0] i_byte_count,
    input  wire logic [TAG_W-1:0]         i_requester,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic      [2:0]               o_status,
    output logic      [TAG_W-1:0]         o_grant_requester,
    output logic      [DEV_W-1:0]         o_grant_device,
    output logic      [FIELD_BYTES_W-1:0] o_grant_bytes,
    output logic                          o_last
);

    localparam int DEV_IW  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES = MAX_DEVICES * QUEUE_DEPTH;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ENT_W   = BYTE_BITS + TAG_W;

    t_state r_state, n_state;

    logic                 r_op;
    logic [DEV_W-1:0]     r_dev;
    logic [BYTE_BITS-1:0] r_bytes;
    logic [TAG_W-1:0]     r_tag;
    logic [DEV_W-1:0]     r_active;

    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [TAG_W-1:0]         r_out_tag;
    logic [DEV_W-1:0]         r_out_dev;
    logic [FIELD_BYTES_W-1:0] r_out_bytes;
    logic                     r_out_last;

    logic                 accept;
    logic                 out_free;
    logic                 dev_ok;
    logic [DEV_IW-1:0]    dev_idx;
    logic [DEV_W-1:0]     ld_dev;
    logic                 ld_en;

    logic [BYTE_BITS-1:0] bud_free;
    logic [PTR_W-1:0]     bud_head;
    logic [PTR_W-1:0]     bud_head_next;
    logic [PTR_W-1:0]     bud_tail;
    logic [CNT_W-1:0]     bud_cnt;
    t_bud_cmd             cmd;
    logic [BYTE_BITS-1:0] opnd;

    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [ADDR_W-1:0]    dev_base;
    logic [ENT_W-1:0]     mem_rdata;
    logic [BYTE_BITS-1:0] ent_bytes;
    logic [TAG_W-1:0]     ent_tag;

    logic                 fits_req;
    logic                 fits_head;
    logic                 queue_full;

    logic                 emit;
    t_status              e_status;
    logic [TAG_W-1:0]     e_tag;
    logic [BYTE_BITS-1:0] e_bytes;
    logic                 e_last;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign dev_ok  = ({1'b0, r_dev} < {1'b0, r_active}) &&
                     ({1'b0, r_dev} < (DEV_W + 1)'(MAX_DEVICES));
    assign dev_idx = r_dev[DEV_IW-1:0];

    // capacity writes load the matching budget counter
    assign ld_dev = i_cfg_idx - CFG_CAP0;
    assign ld_en  = i_cfg_we && (i_cfg_idx >= CFG_CAP0) && (i_cfg_idx <= CFG_CAP3) &&
                    ({1'b0, ld_dev} < (DEV_W + 1)'(MAX_DEVICES));

    assign ent_bytes = mem_rdata[BYTE_BITS-1:0];
    assign ent_tag   = mem_rdata[ENT_W-1 -: TAG_W];

    assign queue_full = (bud_cnt == CNT_W'(QUEUE_DEPTH));
    assign fits_req   = (bud_free >= r_bytes);
    assign fits_head  = (bud_cnt != '0) && (bud_free >= ent_bytes);
    assign opnd       = (r_state == ST_DRAIN) ? ent_bytes : r_bytes;

    assign dev_base  = ADDR_W'(dev_idx) * ADDR_W'(QUEUE_DEPTH);
    assign mem_waddr = dev_base + ADDR_W'(bud_tail);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (dev_ok && (r_op == OP_RELEASE)) begin
                    n_state = ST_DRAIN;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (!fits_head && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        cmd        = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_raddr  = dev_base + ADDR_W'(bud_head);
        emit       = 1'b0;
        e_status   = STAT_GRANT;
        e_tag      = r_tag;
        e_bytes    = r_bytes;
        e_last     = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_EXEC: begin
                if (!dev_ok) begin
                    emit     = out_free;
                    e_status = STAT_INVALID;
                    e_tag    = (r_op == OP_RELEASE) ? '0 : r_tag;
                end else if (r_op == OP_ALLOC) begin
                    emit = out_free;
                    if (fits_req) begin
                        cmd.sub  = out_free;
                        e_status = STAT_GRANT;
                    end else if (!queue_full) begin
                        cmd.push = out_free;
                        mem_we   = out_free;
                        e_status = STAT_QUEUED;
                    end else begin
                        e_status = STAT_FULL;
                    end
                end else begin
                    // release: add back, fetch the queue head
                    cmd.add = 1'b1;
                    mem_re  = 1'b1;
                end
            end
            ST_DRAIN: begin
                emit = out_free;
                if (fits_head) begin
                    cmd.sub   = out_free;
                    cmd.pop   = out_free;
                    mem_re    = out_free;
                    mem_raddr = dev_base + ADDR_W'(bud_head_next);
                    e_status  = STAT_GRANT;
                    e_tag     = ent_tag;
                    e_bytes   = ent_bytes;
                    e_last    = 1'b0;
                end else begin
                    e_status = STAT_DONE;
                    e_tag    = '0;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= DEV_W'(4);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && (i_cfg_idx == CFG_ACTIVE)) begin
                r_active <= i_cfg_wdata[DEV_W-1:0];
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_dev   <= i_device;
            r_bytes <= BYTE_BITS'(i_byte_count);
            r_tag   <= i_requester;
        end
        if (emit) begin
            r_out_status <= e_status;
            r_out_tag    <= e_tag;
            r_out_dev    <= r_dev;
            r_out_bytes  <= FIELD_BYTES_W'(e_bytes);
            r_out_last   <= e_last;
        end
    end

    dmba_budget #(
        .MAX_DEVICES (MAX_DEVICES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .BYTE_BITS   (BYTE_BITS),
        .DEV_IW      (DEV_IW),
        .PTR_W       (PTR_W),
        .CNT_W       (CNT_W)
    ) u_budget (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ld_en     (ld_en),
        .i_ld_dev    (ld_dev[DEV_IW-1:0]),
        .i_ld_val    (BYTE_BITS'(i_cfg_wdata)),
        .i_dev       (dev_idx),
        .i_cmd       (cmd),
        .i_opnd      (opnd),
        .o_free      (bud_free),
        .o_head      (bud_head),
        .o_head_next (bud_head_next),
        .o_tail      (bud_tail),
        .o_cnt       (bud_cnt)
    );

    dmba_wait_mem #(
        .DEPTH  (ENTRIES),
        .WIDTH  (ENT_W),
        .ADDR_W (ADDR_W)
    ) u_wait_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata ({r_tag, r_bytes}),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_grant_requester = r_out_tag;
    assign o_grant_device    = r_out_dev;
    assign o_grant_bytes     = r_out_bytes;
    assign o_last            = r_out_last;

endmodule

`default_nettype wire

// ===== sim/device_memory_budget_allocator_unit_checker.sv =====
`default_nettype none

module device_memory_budget_allocator_unit_checker import dmba_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [FIELD_BYTES_W-1:0] i_cfg_wdata,
    input  wire logic                     i_in_valid,
    input  wire logic                     o_in_ready,
    input  wire logic                     i_op,
    input  wire logic [DEV_W-1:0]         i_device,
    input  wire logic [FIELD_BYTES_W-1:0] i_byte_count,
    input  wire logic [TAG_W-1:0]         i_requester,
    input  wire logic                     o_out_valid,
    input  wire logic                     i_out_ready,
    input  wire logic [2:0]               o_status,
    input  wire logic [TAG_W-1:0]         o_grant_requester,
    input  wire logic [DEV_W-1:0]         o_grant_device,
    input  wire logic [FIELD_BYTES_W-1:0] o_grant_bytes,
    input  wire logic                     o_last,
    output int                            o_fail_count,
    output int                            o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NDEV   = MAX_DEVICES_DEF;
    localparam int QDEPTH = QUEUE_DEPTH_DEF;
    localparam logic [DEV_W-1:0] ACTIVE_AT_RESET = 3'd4;
    localparam logic [FIELD_BYTES_W-1:0] BUDGET_MAX =
        {FIELD_BYTES_W{1'b1}} >> (FIELD_BYTES_W - BYTE_BITS_DEF);
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        t_status                  status;
        logic [TAG_W-1:0]         requester;
        logic [DEV_W-1:0]         device;
        logic [FIELD_BYTES_W-1:0] nbytes;
        logic                     is_last;
    } t_grant_item;

    typedef struct packed {
        logic [FIELD_BYTES_W-1:0] nbytes;
        logic [TAG_W-1:0]         requester;
    } t_waiter;

    logic [DEV_W-1:0]         active_devs;
    logic [FIELD_BYTES_W-1:0] budget [NDEV];
    t_waiter                  waiters [NDEV*QDEPTH];
    int                       wq_head [NDEV];
    int                       wq_tail [NDEV];
    int                       wq_count [NDEV];
    t_grant_item              awaited_results [$];
    int                       mismatches = 0;

    assign o_fail_count = mismatches;
    initial o_outstanding = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic t_grant_item grant_item(input t_status st,
                                               input logic [TAG_W-1:0] tag,
                                               input logic [DEV_W-1:0] dev,
                                               input logic [FIELD_BYTES_W-1:0] nb,
                                               input logic is_last);
        t_grant_item it;
        it.status    = st;
        it.requester = tag;
        it.device    = dev;
        it.nbytes    = nb;
        it.is_last   = is_last;
        return it;
    endfunction

    task automatic reset_budgets();
        active_devs = ACTIVE_AT_RESET;
        for (int d = 0; d < NDEV; d++) begin
            budget[d]   = '0;
            wq_head[d]  = 0;
            wq_tail[d]  = 0;
            wq_count[d] = 0;
        end
        awaited_results.delete();
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [FIELD_BYTES_W-1:0] value);
        if (idx == CFG_ACTIVE)
            active_devs = value[DEV_W-1:0];
        else if (idx >= CFG_CAP0 && idx <= CFG_CAP3)
            // loading a capacity also reloads the free budget of that device
            budget[int'(idx - CFG_CAP0)] = value & BUDGET_MAX;
    endtask

    // Works out every result one request causes and queues them in order.
    task automatic predict_allocation(input logic op, input logic [DEV_W-1:0] dev,
                                      input logic [FIELD_BYTES_W-1:0] raw_bytes,
                                      input logic [TAG_W-1:0] tag);
        logic [FIELD_BYTES_W-1:0] nbytes;
        int d;
        int slot;
        t_waiter head;
        nbytes = raw_bytes & BUDGET_MAX;
        d = int'(dev);
        if (dev >= active_devs || d >= NDEV) begin
            awaited_results.push_back(grant_item(STAT_INVALID,
                (op == OP_RELEASE) ? '0 : tag, dev, nbytes, 1'b1));
        end else if (op == OP_ALLOC) begin
            if (budget[d] >= nbytes) begin
                // fits now: granted even if older requests still wait
                budget[d] -= nbytes;
                awaited_results.push_back(grant_item(STAT_GRANT, tag, dev, nbytes, 1'b1));
            end else if (wq_count[d] < QDEPTH) begin
                slot = d*QDEPTH + wq_tail[d];
                waiters[slot].nbytes    = nbytes;
                waiters[slot].requester = tag;
                wq_tail[d] = (wq_tail[d] + 1) % QDEPTH;
                wq_count[d]++;
                awaited_results.push_back(grant_item(STAT_QUEUED, tag, dev, nbytes, 1'b1));
            end else begin
                awaited_results.push_back(grant_item(STAT_FULL, tag, dev, nbytes, 1'b1));
            end
        end else begin
            if (nbytes > BUDGET_MAX - budget[d])
                budget[d] = BUDGET_MAX;
            else
                budget[d] += nbytes;
            // drain from the head until the head no longer fits
            while (wq_count[d] > 0 && budget[d] >= waiters[d*QDEPTH + wq_head[d]].nbytes) begin
                head = waiters[d*QDEPTH + wq_head[d]];
                budget[d] -= head.nbytes;
                awaited_results.push_back(grant_item(STAT_GRANT, head.requester, dev,
                                                     head.nbytes, 1'b0));
                wq_head[d] = (wq_head[d] + 1) % QDEPTH;
                wq_count[d]--;
            end
            awaited_results.push_back(grant_item(STAT_DONE, '0, dev, nbytes, 1'b1));
        end
    endtask

    always @(posedge i_clk) begin
        t_grant_item want;
        if (!i_rst_n) begin
            reset_budgets();
        end else begin
            if (i_cfg_we)
                apply_register(i_cfg_idx, i_cfg_wdata);
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with nothing awaited, status", 64'(o_status), 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 64'(o_status), 64'(want.status));
                    if (o_grant_requester !== want.requester)
                        report_mismatch("requester", 64'(o_grant_requester),
                                        64'(want.requester));
                    if (o_grant_device !== want.device)
                        report_mismatch("device", 64'(o_grant_device), 64'(want.device));
                    if (o_grant_bytes !== want.nbytes)
                        report_mismatch("bytes", 64'(o_grant_bytes), 64'(want.nbytes));
                    if (o_last !== want.is_last)
                        report_mismatch("last", 64'(o_last), 64'(want.is_last));
                end
            end
            if (i_in_valid && o_in_ready)
                predict_allocation(i_op, i_device, i_byte_count, i_requester);
        end
        o_outstanding <= awaited_results.size();
    end

endmodule

`default_nettype wire

// ===== sim/device_memory_budget_allocator_unit_tb.sv =====
`default_nettype none

module device_memory_budget_allocator_unit_tb import dmba_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [FIELD_BYTES_W-1:0] BYTES_MAX = '1;
    localparam int HOLDOFF_CYCLES = 250;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [FIELD_BYTES_W-1:0] i_cfg_wdata;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic                     i_op;
    logic [DEV_W-1:0]         i_device;
    logic [FIELD_BYTES_W-1:0] i_byte_count;
    logic [TAG_W-1:0]         i_requester;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [2:0]               o_status;
    logic [TAG_W-1:0]         o_grant_requester;
    logic [DEV_W-1:0]         o_grant_device;
    logic [FIELD_BYTES_W-1:0] o_grant_bytes;
    logic                     o_last;

    int fail_count;
    int outstanding;

    bit req_idle_on      = 1'b1;
    bit sink_idle_on     = 1'b1;
    int holdoff_requests = 0;

    device_memory_budget_allocator_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_device          (i_device),
        .i_byte_count      (i_byte_count),
        .i_requester       (i_requester),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_grant_requester (o_grant_requester),
        .o_grant_device    (o_grant_device),
        .o_grant_bytes     (o_grant_bytes),
        .o_last            (o_last)
    );

    device_memory_budget_allocator_unit_checker scoreboard (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_device          (i_device),
        .i_byte_count      (i_byte_count),
        .i_requester       (i_requester),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_grant_requester (o_grant_requester),
        .o_grant_device    (o_grant_device),
        .o_grant_bytes     (o_grant_bytes),
        .o_last            (o_last),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side: random back-pressure plus an occasional long hold-off
    initial begin : result_sink
        int hold_left;
        int holdoffs_seen;
        hold_left     = 0;
        holdoffs_seen = 0;
        i_out_ready   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_requests != holdoffs_seen) begin
                holdoffs_seen = holdoff_requests;
                hold_left     = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 99) < 32) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [FIELD_BYTES_W-1:0] rand40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [FIELD_BYTES_W-1:0] pick_bytes(input logic [FIELD_BYTES_W-1:0] scale);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 10)
            return '1;
        if (r < 18)
            return rand40();
        return rand40() % (scale + 40'd1);
    endfunction

    // Called in the time step of a clock edge; returns in the step of acceptance.
    task automatic send_request(input logic op, input logic [DEV_W-1:0] dev,
                                input logic [FIELD_BYTES_W-1:0] nbytes,
                                input logic [TAG_W-1:0] tag);
        while (req_idle_on && $urandom_range(0, 99) < 32) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_device     <= dev;
        i_byte_count <= nbytes;
        i_requester  <= tag;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic wait_for_all_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    // leaves the write enable high; set_budgets lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [FIELD_BYTES_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic set_budgets(input logic [FIELD_BYTES_W-1:0] active_word,
                               input logic [FIELD_BYTES_W-1:0] cap0,
                               input logic [FIELD_BYTES_W-1:0] cap1,
                               input logic [FIELD_BYTES_W-1:0] cap2,
                               input logic [FIELD_BYTES_W-1:0] cap3,
                               input bit touch_spare);
        wait_for_all_results();
        write_reg(CFG_ACTIVE, active_word);
        write_reg(CFG_CAP0, cap0);
        write_reg(CFG_CAP0 + 3'd1, cap1);
        write_reg(CFG_CAP0 + 3'd2, cap2);
        write_reg(CFG_CAP3, cap3);
        if (touch_spare) begin
            // unused indexes must be ignored
            for (int k = int'(CFG_CAP3) + 1; k < (1 << CFG_IDX_W); k++)
                write_reg(CFG_IDX_W'(k), rand40());
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly bursts of allocations on one device closed by releasing all, half
    // or a quarter of it, so queues fill, overflow and drain; the rest is noise.
    task automatic run_random_traffic(input int n_items, input logic [FIELD_BYTES_W-1:0] scale,
                                      input int n_live);
        int sent;
        int burst;
        int dev;
        logic [FIELD_BYTES_W-1:0] b;
        logic [FIELD_BYTES_W-1:0] total;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 70) begin
                dev   = $urandom_range(0, n_live - 1);
                burst = $urandom_range(2, 20);
                total = '0;
                for (int k = 0; k < burst; k++) begin
                    b = rand40() % (scale + 40'd1);
                    total += b;
                    send_request(OP_ALLOC, DEV_W'(dev), b, TAG_W'($urandom));
                end
                send_request(OP_RELEASE, DEV_W'(dev), total >> $urandom_range(0, 2),
                             TAG_W'($urandom));
                sent += burst + 1;
            end else begin
                send_request(1'($urandom), DEV_W'($urandom), pick_bytes(scale),
                             TAG_W'($urandom));
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_op         = OP_ALLOC;
        i_device     = '0;
        i_byte_count = '0;
        i_requester  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // budgets are zero after reset
        send_request(OP_ALLOC, 3'd0, '0, 8'h00);
        send_request(OP_RELEASE, 3'd0, '0, 8'h3c);
        send_request(OP_ALLOC, 3'd6, BYTES_MAX, 8'hff);
        send_request(OP_RELEASE, 3'd4, BYTES_MAX, 8'h5a);
        // fill one wait queue, overflow it, then drain it all with one release
        for (int k = 0; k < QUEUE_DEPTH_DEF; k++)
            send_request(OP_ALLOC, 3'd3, 40'd1, TAG_W'(k + 1));
        send_request(OP_ALLOC, 3'd3, 40'd1, 8'h77);
        send_request(OP_RELEASE, 3'd3, 40'd16, 8'h00);

        set_budgets(40'd4, 40'd10, BYTES_MAX, 40'd0, 40'd0, 1'b0);
        send_request(OP_ALLOC, 3'd1, BYTES_MAX, 8'ha5);
        send_request(OP_RELEASE, 3'd1, BYTES_MAX, 8'h00);
        send_request(OP_RELEASE, 3'd1, BYTES_MAX, 8'h11);   // saturates
        send_request(OP_ALLOC, 3'd0, 40'd20, 8'h21);
        send_request(OP_ALLOC, 3'd0, 40'd3, 8'h22);         // passes the waiting one
        send_request(OP_RELEASE, 3'd0, 40'd13, 8'h00);

        // upper write-data bits of the device count are don't-care
        set_budgets((rand40() << 3) | 40'd4, 40'($urandom_range(0, 5000)),
                    40'($urandom_range(0, 5000)), 40'($urandom_range(0, 5000)),
                    40'($urandom_range(0, 5000)), 1'b0);
        run_random_traffic(60, 40'd1000, 4);

        wait_for_all_results();
        req_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        run_random_traffic(50, 40'd1000, 4);
        sink_idle_on = 1'b1;

        // receiver stalls while the sender keeps pushing
        wait_for_all_results();
        holdoff_requests++;
        run_random_traffic(40, 40'd500, 4);
        req_idle_on = 1'b1;

        set_budgets(40'd1, BYTES_MAX, rand40(), rand40(), rand40(), 1'b0);
        run_random_traffic(40, 40'h80_0000_0000, 1);

        set_budgets(40'd0, 40'd0, 40'd0, 40'd0, 40'd0, 1'b1);
        run_random_traffic(10, 40'd100, 4);
        set_budgets(40'd7, 40'd50, 40'd50, 40'd50, 40'd50, 1'b0);
        run_random_traffic(20, 40'd100, 4);

        set_budgets(40'd2, rand40(), rand40(), 40'd0, rand40(), 1'b0);
        run_random_traffic(50, 40'h40_0000_0000, 2);

        set_budgets(40'd3, 40'd100, 40'd200, 40'd0, 40'd1, 1'b1);
        run_random_traffic(50, 40'd50, 3);

        wait_for_all_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== device_memory_budget_allocator_unit.f =====
rtl/core/dmba_pkg.sv
rtl/core/dmba_wait_mem.sv
rtl/core/dmba_budget.sv
rtl/core/device_memory_budget_allocator_unit.sv
sim/device_memory_budget_allocator_unit_checker.sv
sim/device_memory_budget_allocator_unit_tb.sv
